/* sv/ttb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Default field widths
  localparam int COORD_WIDTH_DEF = 24;
  localparam int UV_WIDTH_DEF    = 16;

  // Output format: Q1.14, unit length is 1.0
  localparam int OUT_W   = 16;
  localparam int FRAC_SH = 14;
  localparam int ONE_Q14 = 16384;

  // Normalization: the largest magnitude is brought into [2^29, 2^30)
  localparam int NMAG_W = 30;

  // Square root and divider widths
  localparam int SUM_W = 64;
  localparam int DIV_W = 46;
  localparam int Q_W   = 15;
  localparam logic [SUM_W-1:0] SQRT_TOP = {2'b01, {(SUM_W-2){1'b0}}};

  // Sequencer step counts
  localparam int STEP_W     = 5;
  localparam int MUL_STEPS  = 14;
  localparam int SQ_STEPS   = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_LOAD3,
    OP_MUL,
    OP_ACC,
    OP_DEGEN,
    OP_NLOAD,
    OP_SHR,
    OP_SHL,
    OP_ZERO,
    OP_SQ,
    OP_SQACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_PUBLISH
  } ttb_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MACC,
    ST_DEGEN,
    ST_NLOAD,
    ST_NORM,
    ST_SQ,
    ST_SQACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_STORE,
    ST_PUBLISH
  } ttb_state_e;

  typedef struct packed {
    ttb_op_e           op;
    logic [STEP_W-1:0] idx;
    logic              vsel;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic mag_zero;
    logic mag_big;
    logic mag_small;
  } ttb_stat_t;

endpackage

/* sv/triangle_tangent_bitangent.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Tangent and bitangent of a textured triangle, unit length in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one triangle corner per
//   item: position in Q12.12, texture coordinate in Q4.12. The first two
//   corners of a triangle are only stored. The third starts the
//   computation; in_stall_o stays high until its result is handed to the
//   output register.
//   Output channel (out_valid_o / out_stall_i) gives one item per triangle:
//   unit tangent and bitangent, or zero vectors with degenerate_o set when
//   the UV determinant is zero.
//   After the third corner, the shared multiplier forms the det and the six
//   raw components; a zero determinant then goes straight to publish.
//   Otherwise, per vector: load, normalizing shift, sum of squares, square
//   root and three divisions, then publish after the second vector. A zero
//   raw vector skips all but its load and its zero check. The square root
//   (32 steps) and the divider (15 steps per component) take most of the
//   time; no new corner is taken until the result is handed on.
//   A waiting result sits in the output register; corners of the next
//   triangle are taken meanwhile, and its result is held back until the
//   register frees. Reset clears the corner count and the output valid.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent #(
  parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
  parameter int UV_WIDTH    = ttb_pkg::UV_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [UV_WIDTH-1:0]    tex_u_i,
  input  logic signed [UV_WIDTH-1:0]    tex_v_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_z_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_z_o,
  output logic                          degenerate_o
);
  import ttb_pkg::*;

  ttb_cmd_t  cmd;
  ttb_stat_t stat;

  ttb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ttb_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .UV_WIDTH    (UV_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .tex_u_i       (tex_u_i),
    .tex_v_i       (tex_v_i),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .bitangent_x_o (bitangent_x_o),
    .bitangent_y_o (bitangent_y_o),
    .bitangent_z_o (bitangent_z_o),
    .degenerate_o  (degenerate_o)
  );

  // A degenerate item carries zero vectors
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0 &&
       bitangent_x_o == '0 && bitangent_y_o == '0 && bitangent_z_o == '0))
    else $error("degenerate item with nonzero vector");

  // The x components of both unit vectors stay within +/- 1.0
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (tangent_x_o <= OUT_W'(ONE_Q14) && tangent_x_o >= -OUT_W'(ONE_Q14) &&
       bitangent_x_o <= OUT_W'(ONE_Q14) && bitangent_x_o >= -OUT_W'(ONE_Q14)))
    else $error("unit component out of range");

  // A result is only published from a busy sequencer
  a_pub_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result published while idle");

endmodule

/* sv/ttb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_ctrl
// Sequencer: counts corners, steps the shared multiplier, the square root
// and the divider, and owns both handshakes.
// ----------------------------------------------------------------------------
module ttb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  ttb_pkg::ttb_stat_t stat_i,
  output ttb_pkg::ttb_cmd_t  cmd_o
);
  import ttb_pkg::*;

  ttb_state_e        st_q, st_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        comp_q, comp_d;
  logic              vsel_q, vsel_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              ovld_q, ovld_d;
  logic              in_fire;
  logic              out_free;

  assign in_fire  = in_valid_i && (st_q == ST_IDLE);
  assign out_free = !ovld_q || !out_stall_i;

  // Next state
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    comp_d = comp_q;
    vsel_d = vsel_q;
    cnt_d  = cnt_q;
    ovld_d = ovld_q && out_stall_i;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cnt_q == 2'd2) begin
            cnt_d  = 2'd0;
            step_d = '0;
            st_d   = ST_MUL;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      ST_MUL: st_d = ST_MACC;
      ST_MACC: begin
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          vsel_d = 1'b0;
          st_d   = stat_i.det_zero ? ST_DEGEN : ST_NLOAD;
        end else begin
          step_d = step_q + 1'b1;
          st_d   = ST_MUL;
        end
      end
      ST_DEGEN: st_d = ST_PUBLISH;
      ST_NLOAD: st_d = ST_NORM;
      ST_NORM: begin
        if (stat_i.mag_zero) begin
          vsel_d = 1'b1;
          st_d   = vsel_q ? ST_PUBLISH : ST_NLOAD;
        end else if (!stat_i.mag_big && !stat_i.mag_small) begin
          step_d = '0;
          st_d   = ST_SQ;
        end
      end
      ST_SQ: st_d = ST_SQACC;
      ST_SQACC: begin
        if (step_q == STEP_W'(SQ_STEPS - 1)) begin
          st_d = ST_SQRT_INIT;
        end else begin
          step_d = step_q + 1'b1;
          st_d   = ST_SQ;
        end
      end
      ST_SQRT_INIT: begin
        step_d = '0;
        st_d   = ST_SQRT;
      end
      ST_SQRT: begin
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          comp_d = 2'd0;
          st_d   = ST_DIV_INIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV_INIT: begin
        step_d = '0;
        st_d   = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          st_d = ST_DIV_STORE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV_STORE: begin
        if (comp_q == 2'd2) begin
          vsel_d = 1'b1;
          st_d   = vsel_q ? ST_PUBLISH : ST_NLOAD;
        end else begin
          comp_d = comp_q + 2'd1;
          st_d   = ST_DIV_INIT;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          ovld_d = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = step_q;
    cmd_o.vsel = vsel_q;
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.idx = {{(STEP_W-1){1'b0}}, cnt_q[0]};
        if (in_fire) begin
          cmd_o.op = (cnt_q == 2'd2) ? OP_LOAD3 : OP_STORE;
        end
      end
      ST_MUL:       cmd_o.op = OP_MUL;
      ST_MACC:      cmd_o.op = OP_ACC;
      ST_DEGEN:     cmd_o.op = OP_DEGEN;
      ST_NLOAD:     cmd_o.op = OP_NLOAD;
      ST_NORM: begin
        if (stat_i.mag_zero) begin
          cmd_o.op = OP_ZERO;
        end else if (stat_i.mag_big) begin
          cmd_o.op = OP_SHR;
        end else if (stat_i.mag_small) begin
          cmd_o.op = OP_SHL;
        end
      end
      ST_SQ:        cmd_o.op = OP_SQ;
      ST_SQACC:     cmd_o.op = OP_SQACC;
      ST_SQRT_INIT: cmd_o.op = OP_SQRT_INIT;
      ST_SQRT:      cmd_o.op = OP_SQRT_STEP;
      ST_DIV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cmd_o.idx = {{(STEP_W-2){1'b0}}, comp_q};
      end
      ST_DIV:       cmd_o.op = OP_DIV_STEP;
      ST_DIV_STORE: begin
        cmd_o.op  = OP_DIV_STORE;
        cmd_o.idx = {{(STEP_W-2){1'b0}}, comp_q};
      end
      ST_PUBLISH: begin
        if (out_free) begin
          cmd_o.op = OP_PUBLISH;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = ovld_q;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= '0;
      comp_q <= '0;
      vsel_q <= 1'b0;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      comp_q <= comp_d;
      vsel_q <= vsel_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

endmodule

/* sv/ttb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_dp
// Datapath: corner store, shared multiplier with accumulator, normalizing
// shifter, bit-serial square root, restoring divider, result registers.
// ----------------------------------------------------------------------------
module ttb_dp #(
  parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
  parameter int UV_WIDTH    = ttb_pkg::UV_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttb_pkg::ttb_cmd_t             cmd_i,
  output ttb_pkg::ttb_stat_t            stat_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [UV_WIDTH-1:0]    tex_u_i,
  input  logic signed [UV_WIDTH-1:0]    tex_v_i,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] tangent_z_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_x_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_y_o,
  output logic signed [ttb_pkg::OUT_W-1:0] bitangent_z_o,
  output logic                          degenerate_o
);
  import ttb_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int DW = UV_WIDTH + 1;
  localparam int BW = (EW > DW) ? EW : DW;
  localparam int PW = DW + BW;
  localparam int VW = PW + 1;

  // Corner store and deltas
  logic signed [COORD_WIDTH-1:0] spos_q [2][3];
  logic signed [UV_WIDTH-1:0]    su_q [2];
  logic signed [UV_WIDTH-1:0]    sv_q [2];
  logic signed [COORD_WIDTH-1:0] pin [3];
  logic signed [EW-1:0]          e1_q [3];
  logic signed [EW-1:0]          e2_q [3];
  logic signed [DW-1:0]          du1_q, dv1_q, du2_q, dv2_q;

  // Multiplier and accumulator
  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] acc_q;
  logic signed [VW-1:0] res_q [7];
  logic [3:0]           k;
  logic                 det_neg;

  // Normalization
  logic signed [VW-1:0] nval [3];
  logic [VW-1:0]        mag_q [3];
  logic                 neg_q [3];
  logic [VW-1:0]        m01, mmax;
  logic [VW-1:0]        msel;

  // Square root and divider
  logic [2*NMAG_W-1:0]  sqp_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     sx_q, sr_q, sb_q, strial;
  logic [DIV_W-1:0]     drem_q, dsh_q;
  logic [Q_W-1:0]       q_q;
  logic [OUT_W-1:0]     qext, qsig;

  // Working and output results
  logic [OUT_W-1:0] tan_q [3];
  logic [OUT_W-1:0] bit_q [3];
  logic             wdeg_q;
  logic [OUT_W-1:0] otan_q [3];
  logic [OUT_W-1:0] obit_q [3];
  logic             odeg_q;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;
  assign k      = cmd_i.idx[3:0];

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (k)
      4'd0:  begin mul_a = du1_q; mul_b = BW'(dv2_q);   end
      4'd1:  begin mul_a = du2_q; mul_b = BW'(dv1_q);   end
      4'd2:  begin mul_a = dv2_q; mul_b = BW'(e1_q[0]); end
      4'd3:  begin mul_a = dv1_q; mul_b = BW'(e2_q[0]); end
      4'd4:  begin mul_a = dv2_q; mul_b = BW'(e1_q[1]); end
      4'd5:  begin mul_a = dv1_q; mul_b = BW'(e2_q[1]); end
      4'd6:  begin mul_a = dv2_q; mul_b = BW'(e1_q[2]); end
      4'd7:  begin mul_a = dv1_q; mul_b = BW'(e2_q[2]); end
      4'd8:  begin mul_a = du1_q; mul_b = BW'(e2_q[0]); end
      4'd9:  begin mul_a = du2_q; mul_b = BW'(e1_q[0]); end
      4'd10: begin mul_a = du1_q; mul_b = BW'(e2_q[1]); end
      4'd11: begin mul_a = du2_q; mul_b = BW'(e1_q[1]); end
      4'd12: begin mul_a = du1_q; mul_b = BW'(e2_q[2]); end
      4'd13: begin mul_a = du2_q; mul_b = BW'(e1_q[2]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign det_neg = res_q[0][VW-1];

  // Raw vector fetch and magnitude search
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nval[j] = cmd_i.vsel ? res_q[4+j] : res_q[1+j];
    end
    m01  = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    mmax = (m01 > mag_q[2]) ? m01 : mag_q[2];
    case (cmd_i.idx[1:0])
      2'd1:    msel = mag_q[1];
      2'd2:    msel = mag_q[2];
      default: msel = mag_q[0];
    endcase
  end

  assign stat_o.det_zero  = (res_q[0] == '0);
  assign stat_o.mag_zero  = (mmax == '0);
  assign stat_o.mag_big   = |mmax[VW-1:NMAG_W];
  assign stat_o.mag_small = ~|mmax[VW-1:NMAG_W-1];

  assign strial = sr_q + sb_q;
  assign qext   = {{(OUT_W-Q_W){1'b0}}, q_q};
  assign qsig   = neg_q[cmd_i.idx[1:0]] ? (~qext + 1'b1) : qext;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_STORE: begin
        for (int j = 0; j < 3; j++) begin
          spos_q[cmd_i.idx[0]][j] <= pin[j];
        end
        su_q[cmd_i.idx[0]] <= tex_u_i;
        sv_q[cmd_i.idx[0]] <= tex_v_i;
      end
      OP_LOAD3: begin
        for (int j = 0; j < 3; j++) begin
          e1_q[j] <= EW'(spos_q[1][j]) - EW'(spos_q[0][j]);
          e2_q[j] <= EW'(pin[j]) - EW'(spos_q[0][j]);
        end
        du1_q <= DW'(su_q[1]) - DW'(su_q[0]);
        dv1_q <= DW'(sv_q[1]) - DW'(sv_q[0]);
        du2_q <= DW'(tex_u_i) - DW'(su_q[0]);
        dv2_q <= DW'(tex_v_i) - DW'(sv_q[0]);
        wdeg_q <= 1'b0;
      end
      OP_MUL: prod_q <= mul_a * mul_b;
      OP_ACC: begin
        if (!k[0]) begin
          acc_q <= prod_q;
        end else begin
          res_q[k[3:1]] <= VW'(acc_q) - VW'(prod_q);
        end
      end
      OP_DEGEN: begin
        for (int j = 0; j < 3; j++) begin
          tan_q[j] <= '0;
          bit_q[j] <= '0;
        end
        wdeg_q <= 1'b1;
      end
      OP_NLOAD: begin
        for (int j = 0; j < 3; j++) begin
          mag_q[j] <= nval[j][VW-1] ? VW'(-nval[j]) : VW'(nval[j]);
          neg_q[j] <= nval[j][VW-1] ^ det_neg;
        end
      end
      OP_SHR: begin
        for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
      end
      OP_SHL: begin
        for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] << 1;
      end
      OP_ZERO: begin
        for (int j = 0; j < 3; j++) begin
          if (cmd_i.vsel) bit_q[j] <= '0;
          else            tan_q[j] <= '0;
        end
      end
      OP_SQ: sqp_q <= msel[NMAG_W-1:0] * msel[NMAG_W-1:0];
      OP_SQACC: begin
        sum_q <= ((cmd_i.idx == '0) ? '0 : sum_q) + SUM_W'(sqp_q);
      end
      OP_SQRT_INIT: begin
        sx_q <= sum_q;
        sr_q <= '0;
        sb_q <= SQRT_TOP;
      end
      OP_SQRT_STEP: begin
        if (sx_q >= strial) begin
          sx_q <= sx_q - strial;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_DIV_INIT: begin
        drem_q <= DIV_W'({msel[NMAG_W-1:0], {FRAC_SH{1'b0}}}) + DIV_W'(sr_q[NMAG_W:1]);
        dsh_q  <= DIV_W'({sr_q[NMAG_W:0], {FRAC_SH{1'b0}}});
        q_q    <= '0;
      end
      OP_DIV_STEP: begin
        if (drem_q >= dsh_q) begin
          drem_q <= drem_q - dsh_q;
          q_q    <= {q_q[Q_W-2:0], 1'b1};
        end else begin
          q_q    <= {q_q[Q_W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      OP_DIV_STORE: begin
        for (int j = 0; j < 3; j++) begin
          if (cmd_i.idx[1:0] == 2'(j)) begin
            if (cmd_i.vsel) bit_q[j] <= qsig;
            else            tan_q[j] <= qsig;
          end
        end
      end
      OP_PUBLISH: begin
        for (int j = 0; j < 3; j++) begin
          otan_q[j] <= tan_q[j];
          obit_q[j] <= bit_q[j];
        end
      end
      default: ;
    endcase
  end

  // Degenerate flag of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odeg_q <= 1'b0;
    end else if (cmd_i.op == OP_PUBLISH) begin
      odeg_q <= wdeg_q;
    end
  end

  assign tangent_x_o   = otan_q[0];
  assign tangent_y_o   = otan_q[1];
  assign tangent_z_o   = otan_q[2];
  assign bitangent_x_o = obit_q[0];
  assign bitangent_y_o = obit_q[1];
  assign bitangent_z_o = obit_q[2];
  assign degenerate_o  = odeg_q;

endmodule
